@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define OVL_ASSERT_IMM(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("ordered value list check failed");

// Next-cycle implication, quiet while reset is asserted.
`define OVL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("ordered value list check failed");

`endif

@@ hw/rtl/ovl_pkg.sv @@
// Shared constants, codes and types of the ordered value list.
package ovl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_MODIFY = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef logic signed [DATA_W-1:0] data_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic  exec;
    op_e   op;
    data_t key;
    data_t repl;
  } cmd_t;

  // Contents of one cell as seen by its neighbours.
  typedef struct packed {
    logic  valid;
    data_t value;
  } slot_t;

endpackage

@@ hw/rtl/ovl_cell.sv @@
// One list cell: holds an entry, compares it and shifts with its neighbours.
module ovl_cell import ovl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  slot_t right_i,
  input  logic  left_valid_i,
  input  logic  prior_hit_i,
  output logic  prior_hit_o,
  output logic  first_hit_o,
  output slot_t slot_o
);

  logic  valid_q, valid_d;
  data_t entry_q, entry_d;
  logic  hit;

  assign hit         = valid_q && (entry_q == cmd_i.key);
  assign first_hit_o = hit && !prior_hit_i;
  assign prior_hit_o = prior_hit_i || hit;
  assign slot_o      = '{valid: valid_q, value: entry_q};

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (cmd_i.exec) begin
      unique case (cmd_i.op)
        OP_APPEND: begin
          // The tail slot is the first empty cell after a full one.
          if (!valid_q && left_valid_i) begin
            valid_d = 1'b1;
            entry_d = cmd_i.key;
          end
        end
        OP_DELETE: begin
          // Close the gap: from the first match onwards take the right neighbour.
          if (prior_hit_o) begin
            valid_d = right_i.valid;
            entry_d = right_i.value;
          end
        end
        OP_MODIFY: begin
          if (first_hit_o) begin
            entry_d = cmd_i.repl;
          end
        end
        OP_SEARCH: begin
          // Hold.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ hw/rtl/ordered_value_list.sv @@
// An accepted beat is held in the command registers, executed along the cell row, then held in the result register.
// The cell row executes one command at a time; the input stalls while a command is in execution.
// The execute cycle covers the compare in every cell and the first-match chain along the row.
// A new beat is taken while a finished result still waits, if that result leaves this cycle.
// Reset (rst_ni, asynchronous, active low) empties the list and drops any pending result.
// Entry contents are not cleared; only occupied cells are ever compared or reported.
module ordered_value_list import ovl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [OP_W-1:0]      operation_i,
  input  logic signed [31:0]   value_i,
  input  logic signed [31:0]   new_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [POS_W-1:0]     match_position_o,
  output logic [LEN_W-1:0]     list_length_o
);

  // Input side: capture the beat, then execute it in the following cycle.
  logic  in_acc;
  logic  busy_q;
  op_e   op_q;
  data_t key_q, repl_q;
  cmd_t  cmd;

  // Result register.
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [POS_W-1:0]  pos_q;
  logic [IDX_W-1:0]  pos_d;
  logic [CNT_W-1:0]  count_q, count_d;

  // Cell row wiring.
  slot_t            slot      [CAPACITY];
  slot_t            right_slot[CAPACITY];
  logic             left_valid[CAPACITY];
  logic             first_hit [CAPACITY];
  logic             prior_hit [CAPACITY+1];
  logic             any_hit;
  logic             full;
  logic [IDX_W-1:0] first_pos;

  // Accept only when idle and the result register is free by the execute cycle.
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= op_e'(operation_i);
      key_q  <= value_i;
      repl_q <= new_value_i;
    end
  end

  assign cmd = '{exec: busy_q, op: op_q, key: key_q, repl: repl_q};

  // The row: cell 0 is the head, each cell sees its left occupancy and right contents.
  assign prior_hit[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_valid[g] = 1'b1;
    end else begin : g_body
      assign left_valid[g] = slot[g-1].valid;
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign right_slot[g] = '0;
    end else begin : g_inner
      assign right_slot[g] = slot[g+1];
    end

    ovl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .right_i      (right_slot[g]),
      .left_valid_i (left_valid[g]),
      .prior_hit_i  (prior_hit[g]),
      .prior_hit_o  (prior_hit[g+1]),
      .first_hit_o  (first_hit[g]),
      .slot_o       (slot[g])
    );
  end

  assign any_hit = prior_hit[CAPACITY];
  assign full    = slot[CAPACITY-1].valid;

  // At most one cell flags the first match, so OR its index in.
  always_comb begin
    first_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        first_pos = first_pos | IDX_W'(i);
      end
    end
  end

  // Status, position and new length of the command in execution.
  // The held operation is only looked at in the execute cycle.
  always_comb begin
    status_d = ST_DONE;
    pos_d    = '0;
    count_d  = count_q;
    if (busy_q) begin
      unique case (op_q)
        OP_APPEND: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            pos_d   = count_q[IDX_W-1:0];
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_DELETE, OP_SEARCH, OP_MODIFY: begin
          if (!any_hit) begin
            status_d = ST_NOT_FOUND;
          end else begin
            pos_d = first_pos;
            if (op_q == OP_DELETE) begin
              count_d = count_q - CNT_W'(1);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (busy_q) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: loaded in the execute cycle, held while stalled.
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      status_q <= status_d;
      pos_q    <= POS_W'(pos_d);
    end
  end

  // The length follows the count, which only moves in the execute cycle.
  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign match_position_o = pos_q;
  assign list_length_o    = LEN_W'(count_q);

endmodule

@@ hw/rtl/ovl_checker.sv @@
// Port-level checks of the ordered value list, bound to the top level.
`include "assert_macros.svh"

module ovl_checker import ovl_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [STATUS_W-1:0]  status_o,
  input logic [POS_W-1:0]     match_position_o,
  input logic [LEN_W-1:0]     list_length_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // A stalled result holds.
  `OVL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(match_position_o) && $stable(list_length_o))

  // One command at a time: stall right after taking a beat.
  `OVL_ASSERT_NEXT(a_busy_stall, clk_i, rst_ni, in_beat, in_stall_o)

  // Every accepted beat yields a result, once it has passed the command and result registers.
  `OVL_ASSERT_IMM(a_result_due, clk_i, rst_ni, in_beat, ##2 out_valid_o)

  // A full report comes only with the list at capacity.
  `OVL_ASSERT_IMM(a_full_len, clk_i, rst_ni,
    out_valid_o && (status_o == ST_FULL), list_length_o == LEN_W'(CAPACITY))

  // Position is zero unless the operation succeeded.
  `OVL_ASSERT_IMM(a_pos_zero, clk_i, rst_ni,
    out_valid_o && (status_o != ST_DONE), match_position_o == '0)

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (.*);
